/* design/ffca_pkg.sv */
`default_nettype none
package ffca_pkg;

	// sequencer states
	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_SCAN   = 10'b0000000010,
		ST_SCHK   = 10'b0000000100,
		ST_GROW   = 10'b0000001000,
		ST_APPEND = 10'b0000010000,
		ST_BREAD  = 10'b0000100000,
		ST_BCHK   = 10'b0001000000,
		ST_BSWAP  = 10'b0010000000,
		ST_BSWAP2 = 10'b0100000000,
		ST_DONE   = 10'b1000000000
	} state_t;

	localparam logic       FUNC_ALLOC     = 1'b0;
	localparam logic       FUNC_FREE      = 1'b1;
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_FAIL    = 2'd1;
	localparam logic [1:0] STATUS_NOTFND  = 2'd2;
	localparam logic       REG_BASE       = 1'b0;
	localparam logic       REG_LIMIT      = 1'b1;
	localparam int         GROW_FACTOR    = 4;

	// one table entry: start, size, free flag
	typedef struct packed {
		logic [31:0] start;
		logic [31:0] size;
		logic        free;
	} entry_t;

endpackage
`default_nettype wire

/* design/first_fit_chunk_allocator.sv */
// Sequence: a scan over the E entries, then a bubble-up for each appended
//   entry (up to two appends).
// Throughput: one transaction at a time, using the single table RAM port pair.
// Reset: entry count cleared, break pointer to 0 (the region_base reset),
//   region_limit to all ones; table contents are undefined until written.
`default_nettype none
module first_fit_chunk_allocator #(
	parameter int TABLE_ENTRIES = 64,
	parameter int HEADER_BYTES  = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        func,
	input  wire logic [23:0] request_size,
	input  wire logic [31:0] address,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      address_out,
	output logic [1:0]       status,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int EW = $bits(ffca_pkg::entry_t);

	ffca_pkg::state_t state_q;
	logic [31:0]      limit_q, brk_q;
	logic [CW-1:0]    count_q;
	logic [AW-1:0]    idx_q, par_q;
	logic             func_q;
	logic [23:0]      n_q;
	logic [31:0]      addr_q;
	ffca_pkg::entry_t cur_q, par_e_q, pend_q;
	logic             pend_v_q;
	logic [1:0]       stat_q;
	logic [31:0]      res_q;

	// table RAM
	logic             we;
	logic [AW-1:0]    waddr, raddr;
	ffca_pkg::entry_t wdata, rdata;

	ffca_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// shared adder/compare unit
	logic [33:0] op_a, op_b, sum;
	assign sum = op_a + op_b;

	logic [33:0] total;
	assign total = {10'd0, n_q} * 34'(1 + ffca_pkg::GROW_FACTOR) + 34'(HEADER_BYTES);

	logic [AW-1:0] parent_idx;
	assign parent_idx = AW'((idx_q - AW'(1)) >> 1);

	logic fit, sa, last_scan;
	assign fit = rdata.free && (rdata.size >= {8'd0, n_q});
	assign sa  = (func_q == ffca_pkg::FUNC_FREE) ? (rdata.start == addr_q) : fit;
	assign last_scan = ({1'b0, idx_q} + (CW+1)'(1)) >= (CW+1)'(count_q);

	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			ffca_pkg::ST_SCHK: begin
				op_a = {2'd0, rdata.start};
				op_b = 34'(n_q) + 34'(HEADER_BYTES);
			end
			ffca_pkg::ST_GROW: begin
				op_a = {2'd0, brk_q};
				op_b = total;
			end
			default: begin
				op_a = {2'd0, brk_q};
				op_b = 34'(HEADER_BYTES);
			end
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = cur_q;
		raddr = idx_q;
		unique case (state_q)
			ffca_pkg::ST_SCHK: begin
				we = sa;
				wdata = rdata;
				wdata.free = (func_q == ffca_pkg::FUNC_FREE);
				if (func_q == ffca_pkg::FUNC_ALLOC &&
						{2'd0, rdata.size} > 34'(n_q) + 34'(HEADER_BYTES)) begin
					wdata.size = {8'd0, n_q};
				end
			end
			ffca_pkg::ST_APPEND: begin
				we = (count_q < CW'(TABLE_ENTRIES));
				waddr = AW'(count_q);
				wdata = pend_q;
			end
			ffca_pkg::ST_BREAD: raddr = parent_idx;
			ffca_pkg::ST_BSWAP: begin
				we = 1'b1;
				waddr = par_q;
				wdata = cur_q;
			end
			ffca_pkg::ST_BSWAP2: begin
				we = 1'b1;
				waddr = idx_q;
				wdata = par_e_q;
			end
			default: ;
		endcase
	end

	assign in_ready = (state_q == ffca_pkg::ST_IDLE) && !out_valid;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ffca_pkg::ST_IDLE;
			limit_q   <= '1;
			brk_q     <= '0;
			count_q   <= '0;
			out_valid <= 1'b0;
			pend_v_q  <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == ffca_pkg::REG_BASE) begin
					brk_q  <= cfg_data;
				end else begin
					limit_q <= cfg_data;
				end
			end
			unique case (state_q)
				ffca_pkg::ST_IDLE: begin
					if (in_valid && in_ready) begin
						func_q   <= func;
						n_q      <= request_size;
						addr_q   <= address;
						idx_q    <= '0;
						pend_v_q <= 1'b0;
						res_q    <= '0;
						if (func == ffca_pkg::FUNC_ALLOC && request_size == '0) begin
							stat_q  <= ffca_pkg::STATUS_FAIL;
							state_q <= ffca_pkg::ST_DONE;
						end else if (count_q == '0) begin
							state_q <= (func == ffca_pkg::FUNC_FREE) ?
								ffca_pkg::ST_DONE : ffca_pkg::ST_GROW;
							stat_q  <= ffca_pkg::STATUS_NOTFND;
						end else begin
							state_q <= ffca_pkg::ST_SCAN;
						end
					end
				end
				ffca_pkg::ST_SCAN: state_q <= ffca_pkg::ST_SCHK;
				ffca_pkg::ST_SCHK: begin
					if (sa) begin
						stat_q <= ffca_pkg::STATUS_OK;
						if (func_q == ffca_pkg::FUNC_FREE) begin
							state_q <= ffca_pkg::ST_DONE;
						end else begin
							res_q <= rdata.start;
							if ({2'd0, rdata.size} > 34'(n_q) + 34'(HEADER_BYTES)) begin
								pend_q.start <= sum[31:0];
								pend_q.size  <= rdata.size - 32'(n_q) - 32'(HEADER_BYTES);
								pend_q.free  <= 1'b1;
								state_q <= ffca_pkg::ST_APPEND;
							end else begin
								state_q <= ffca_pkg::ST_DONE;
							end
						end
					end else if (last_scan) begin
						if (func_q == ffca_pkg::FUNC_FREE) begin
							stat_q  <= ffca_pkg::STATUS_NOTFND;
							state_q <= ffca_pkg::ST_DONE;
						end else begin
							state_q <= ffca_pkg::ST_GROW;
						end
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= ffca_pkg::ST_SCAN;
					end
				end
				ffca_pkg::ST_GROW: begin
					if (sum > {2'd0, limit_q} + 34'd1) begin
						stat_q  <= ffca_pkg::STATUS_FAIL;
						state_q <= ffca_pkg::ST_DONE;
					end else begin
						stat_q       <= ffca_pkg::STATUS_OK;
						brk_q        <= sum[31:0];
						res_q        <= brk_q + 32'(HEADER_BYTES);
						pend_q.start <= brk_q + 32'(HEADER_BYTES);
						pend_q.size  <= {8'd0, n_q};
						pend_q.free  <= 1'b0;
						pend_v_q     <= ({8'd0, n_q, 2'b00} > 34'(HEADER_BYTES));
						state_q      <= ffca_pkg::ST_APPEND;
					end
				end
				ffca_pkg::ST_APPEND: begin
					if (count_q < CW'(TABLE_ENTRIES)) begin
						idx_q   <= AW'(count_q);
						cur_q   <= pend_q;
						count_q <= count_q + CW'(1);
						state_q <= (count_q == '0) ? ffca_pkg::ST_BCHK : ffca_pkg::ST_BREAD;
					end else begin
						// full table: drop this entry, no bubble-up
						state_q <= pend_v_q ? ffca_pkg::ST_APPEND : ffca_pkg::ST_DONE;
					end
					// queue the grow leftover behind the used chunk
					if (pend_v_q) begin
						pend_v_q     <= 1'b0;
						pend_q.start <= res_q + 32'(n_q) + 32'(HEADER_BYTES);
						pend_q.size  <= {6'd0, n_q, 2'b00} - 32'(HEADER_BYTES);
						pend_q.free  <= 1'b1;
					end else begin
						pend_q.size <= '0;
						pend_q.free <= 1'b0;
						pend_q.start <= '1;
					end
				end
				ffca_pkg::ST_BREAD: begin
					par_q   <= parent_idx;
					state_q <= ffca_pkg::ST_BCHK;
				end
				ffca_pkg::ST_BCHK: begin
					if (idx_q != '0 && par_q == parent_idx && cur_q.size < rdata.size
							&& count_q != '0) begin
						par_e_q <= rdata;
						state_q <= ffca_pkg::ST_BSWAP;
					end else if (pend_q.start != '1 || pend_q.free) begin
						state_q <= ffca_pkg::ST_APPEND;
					end else begin
						state_q <= ffca_pkg::ST_DONE;
					end
				end
				ffca_pkg::ST_BSWAP: state_q <= ffca_pkg::ST_BSWAP2;
				ffca_pkg::ST_BSWAP2: begin
					idx_q   <= par_q;
					state_q <= (par_q == '0) ? ffca_pkg::ST_BCHK : ffca_pkg::ST_BREAD;
				end
				ffca_pkg::ST_DONE: begin
					if (!out_valid) begin
						address_out <= (stat_q == ffca_pkg::STATUS_OK) ? res_q : '0;
						status      <= stat_q;
						out_valid   <= 1'b1;
						state_q     <= ffca_pkg::ST_IDLE;
					end
				end
				default: state_q <= ffca_pkg::ST_IDLE;
			endcase
		end
	end

	// a transaction is only taken while nothing is pending
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> !out_valid)
		else $error("accept with pending result");
	// the table never overfills
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_ENTRIES))
		else $error("entry count overflow");
	// a result appears only from the done state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ffca_pkg::ST_DONE))
		else $error("unexpected result");

endmodule
`default_nettype wire

/* design/ffca_ram.sv */
`default_nettype none
module ffca_ram #(
	parameter int WIDTH = 65,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire
